FILE: rtl/gnz_pkg.sv
package gnz_pkg;

    localparam int TABLE_SIZE = 256;
    localparam int IDX_W      = $clog2(TABLE_SIZE);
    localparam int PERM_W     = 8;
    localparam int FRAC_BITS  = 16;
    localparam int PIX_W      = 12;
    localparam int SCALE_W    = 24;
    localparam int COORD_W    = PIX_W + SCALE_W;
    localparam int NOISE_W    = 19;
    localparam int FX_W       = 22;
    localparam int PROD_W     = 2 * FX_W;

    localparam logic [SCALE_W-1:0] SCALE_RESET = SCALE_W'(6554);

    typedef logic signed [FX_W-1:0]   fx_t;
    typedef logic signed [PROD_W-1:0] prod_t;

    localparam fx_t   FX_ONE    = fx_t'(1) <<< FRAC_BITS;
    localparam fx_t   FX_FIFTEEN = fx_t'(15) <<< FRAC_BITS;
    localparam fx_t   FX_TEN    = fx_t'(10) <<< FRAC_BITS;
    localparam prod_t PROD_HALF = prod_t'(1) <<< (FRAC_BITS - 1);

    typedef enum logic {
        OP_LOAD   = 1'b0,
        OP_SAMPLE = 1'b1
    } op_t;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  addr;
        logic [PERM_W-1:0] data;
    } perm_wr_t;

    // Product back to FRAC_BITS fraction bits, rounding half up.
    function automatic fx_t rnd(input prod_t m);
        prod_t s;
        s = m + PROD_HALF;
        return fx_t'(s[FRAC_BITS+FX_W-1:FRAC_BITS]);
    endfunction

    function automatic fx_t grad(input logic [3:0] h, input fx_t x, input fx_t y);
        fx_t u;
        fx_t v;
        u = (h < 4'd8) ? x : y;
        if (h < 4'd4)
            v = y;
        else
        begin
            case (h) inside
                4'd12, 4'd14: v = x;
                default:      v = '0;
            endcase
        end
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

endpackage

FILE: rtl/gnz_if.sv
interface gnz_item_if;
    logic                           valid;
    logic                           ready;
    gnz_pkg::op_t                   op;
    logic [gnz_pkg::IDX_W-1:0]      table_index;
    logic [gnz_pkg::PERM_W-1:0]     table_value;
    logic [gnz_pkg::PIX_W-1:0]      pixel_x;
    logic [gnz_pkg::PIX_W-1:0]      pixel_y;

    modport source(output valid, op, table_index, table_value, pixel_x, pixel_y,
                   input ready);
    modport sink(input valid, op, table_index, table_value, pixel_x, pixel_y,
                 output ready);
endinterface

interface gnz_result_if;
    logic                               valid;
    logic                               ready;
    logic signed [gnz_pkg::NOISE_W-1:0] noise_value;
    logic                               above_zero;

    modport source(output valid, noise_value, above_zero, input ready);
    modport sink(input valid, noise_value, above_zero, output ready);
endinterface

FILE: rtl/gnz_perm_ram.sv
module gnz_perm_ram (
    input  logic                          clk,
    input  gnz_pkg::perm_wr_t             wr,
    input  logic                          re,
    input  logic [gnz_pkg::IDX_W-1:0]     raddr_a,
    input  logic [gnz_pkg::IDX_W-1:0]     raddr_b,
    output logic [gnz_pkg::PERM_W-1:0]    rdata_a,
    output logic [gnz_pkg::PERM_W-1:0]    rdata_b
);

    logic [gnz_pkg::PERM_W-1:0] mem [gnz_pkg::TABLE_SIZE];

    always_ff @(posedge clk)
    begin
        if (wr.we)
            mem[wr.addr] <= wr.data;
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_a <= mem[raddr_a];
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

FILE: rtl/gnz_fade.sv
module gnz_fade (
    input  logic                             clk,
    input  logic [3:0]                       en,
    input  logic [gnz_pkg::FRAC_BITS-1:0]    t,
    output gnz_pkg::fx_t                     fade
);

    gnz_pkg::fx_t  t1, a1, p2, p3, p4;
    gnz_pkg::fx_t  t2_reg, t3_reg, t4_reg;
    gnz_pkg::prod_t m1_next, m2_next, m3_next, m4_next;
    gnz_pkg::prod_t m1_reg, m2_reg, m3_reg, m4_reg;

    // Horner form: t*(6t - 15) + 10, then three more products by t.
    always_comb
    begin
        t1      = gnz_pkg::fx_t'(t);
        a1      = (t1 <<< 2) + (t1 <<< 1) - gnz_pkg::FX_FIFTEEN;
        m1_next = gnz_pkg::prod_t'(a1) * gnz_pkg::prod_t'(t1);
        p2      = gnz_pkg::rnd(m1_reg) + gnz_pkg::FX_TEN;
        m2_next = gnz_pkg::prod_t'(p2) * gnz_pkg::prod_t'(t2_reg);
        p3      = gnz_pkg::rnd(m2_reg);
        m3_next = gnz_pkg::prod_t'(p3) * gnz_pkg::prod_t'(t3_reg);
        p4      = gnz_pkg::rnd(m3_reg);
        m4_next = gnz_pkg::prod_t'(p4) * gnz_pkg::prod_t'(t4_reg);
        fade    = gnz_pkg::rnd(m4_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            m1_reg <= m1_next;
            t2_reg <= t1;
        end
        if (en[1])
        begin
            m2_reg <= m2_next;
            t3_reg <= t2_reg;
        end
        if (en[2])
        begin
            m3_reg <= m3_next;
            t4_reg <= t3_reg;
        end
        if (en[3])
            m4_reg <= m4_next;
    end

endmodule

FILE: rtl/gradient_noise_2d_core.sv
// Channel   Dir  Fields
// items     in   op, table_index, table_value, pixel_x, pixel_y
// results   out  noise_value (signed Q2.16), above_zero
// cfg_*     in   coord_scale (Q8.16), written when cfg_we is high
//
// One sample word per cycle unless results stall; the last stage holds the offered result.
// The table lives in five copies of a 256-entry RAM with two read ports: one copy for the
// first of three dependent lookup levels and two for each of the other two, so every
// sample does its ten reads in three pipeline steps. A load word is held off until no
// sample sits in the three lookup stages, also while a stall holds a sample there.
// Each stage moves when the one ahead is empty or moving, so bubbles close up under stall.
// Reset clears valid bits and sets coord_scale to 6554; the table is undefined until loaded.
module gradient_noise_2d_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [gnz_pkg::SCALE_W-1:0]         cfg_wdata,
    gnz_item_if.sink                            items,
    gnz_result_if.source                        results
);

    localparam int IW = gnz_pkg::IDX_W;
    localparam int FB = gnz_pkg::FRAC_BITS;

    logic [gnz_pkg::SCALE_W-1:0] scale_reg;
    logic [9:1] v_reg;
    logic [9:1] en;
    logic       lookup_busy, acc_sample, acc_load;

    logic [gnz_pkg::COORD_W-1:0] cx_next, cy_next;
    logic [FB-1:0] fx1_reg, fy1_reg, fx2_reg, fy2_reg, fx3_reg, fy3_reg, fx4_reg, fy4_reg;
    logic [IW-1:0] x1_reg, y1_reg, y2_reg;
    logic [IW-1:0] rd0a, rd0b, a_next, b_next;
    logic [IW-1:0] aa, ab, ba, bb;
    logic [IW-1:0] h_aa, h_ab, h_ba, h_bb;
    gnz_pkg::perm_wr_t wr;

    gnz_pkg::fx_t u_fade, v_fade, x0, y0, x1m, y1m;
    gnz_pkg::fx_t g00_reg, g10_reg, g01_reg, g11_reg, g00_6_reg, g01_6_reg, v6_reg, v7_reg;
    gnz_pkg::prod_t pu1_reg, pu2_reg, pv_reg;
    gnz_pkg::fx_t l1_reg, l2_reg, l1_8_reg, val_next;
    logic signed [gnz_pkg::NOISE_W-1:0] noise_reg;
    logic above_reg;

    // Stage enables: a stage loads when it is empty or the stage ahead loads.
    always_comb
    begin
        en[9] = !v_reg[9] || results.ready;
        for (int k = 8; k >= 1; k--)
            en[k] = !v_reg[k] || en[k+1];
    end

    assign lookup_busy   = v_reg[1] || v_reg[2] || v_reg[3];
    assign items.ready   = (items.op == gnz_pkg::OP_SAMPLE) ? en[1] : !lookup_busy;
    assign acc_sample    = items.valid && items.ready && items.op == gnz_pkg::OP_SAMPLE;
    assign acc_load      = items.valid && items.ready && items.op == gnz_pkg::OP_LOAD;

    assign wr.we   = acc_load;
    assign wr.addr = items.table_index;
    assign wr.data = items.table_value;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_reg <= gnz_pkg::SCALE_RESET;
            v_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
                scale_reg <= cfg_wdata;
            if (en[1])
                v_reg[1] <= acc_sample;
            for (int k = 2; k <= 9; k++)
            begin
                if (en[k])
                    v_reg[k] <= v_reg[k-1];
            end
        end
    end

    assign cx_next = gnz_pkg::COORD_W'(items.pixel_x) * gnz_pkg::COORD_W'(scale_reg);
    assign cy_next = gnz_pkg::COORD_W'(items.pixel_y) * gnz_pkg::COORD_W'(scale_reg);
    assign a_next  = rd0a + y2_reg;
    assign b_next  = rd0b + y2_reg;

    gnz_perm_ram u_ram0 (.clk(clk), .wr(wr), .re(en[2]),
        .raddr_a(x1_reg), .raddr_b(IW'(x1_reg + 1'b1)), .rdata_a(rd0a), .rdata_b(rd0b));
    gnz_perm_ram u_ram1 (.clk(clk), .wr(wr), .re(en[3]),
        .raddr_a(a_next), .raddr_b(IW'(a_next + 1'b1)), .rdata_a(aa), .rdata_b(ab));
    gnz_perm_ram u_ram2 (.clk(clk), .wr(wr), .re(en[3]),
        .raddr_a(b_next), .raddr_b(IW'(b_next + 1'b1)), .rdata_a(ba), .rdata_b(bb));
    gnz_perm_ram u_ram3 (.clk(clk), .wr(wr), .re(en[4]),
        .raddr_a(aa), .raddr_b(ab), .rdata_a(h_aa), .rdata_b(h_ab));
    gnz_perm_ram u_ram4 (.clk(clk), .wr(wr), .re(en[4]),
        .raddr_a(ba), .raddr_b(bb), .rdata_a(h_ba), .rdata_b(h_bb));

    gnz_fade u_fade_x (.clk(clk), .en(en[5:2]), .t(fx1_reg), .fade(u_fade));
    gnz_fade u_fade_y (.clk(clk), .en(en[5:2]), .t(fy1_reg), .fade(v_fade));

    always_comb
    begin
        x0       = gnz_pkg::fx_t'(fx4_reg);
        y0       = gnz_pkg::fx_t'(fy4_reg);
        x1m      = x0 - gnz_pkg::FX_ONE;
        y1m      = y0 - gnz_pkg::FX_ONE;
        val_next = l1_8_reg + gnz_pkg::rnd(pv_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            fx1_reg <= cx_next[FB-1:0];
            fy1_reg <= cy_next[FB-1:0];
            x1_reg  <= cx_next[FB+IW-1:FB];
            y1_reg  <= cy_next[FB+IW-1:FB];
        end
        if (en[2])
        begin
            y2_reg  <= y1_reg;
            fx2_reg <= fx1_reg;
            fy2_reg <= fy1_reg;
        end
        if (en[3])
        begin
            fx3_reg <= fx2_reg;
            fy3_reg <= fy2_reg;
        end
        if (en[4])
        begin
            fx4_reg <= fx3_reg;
            fy4_reg <= fy3_reg;
        end
        if (en[5])
        begin
            g00_reg <= gnz_pkg::grad(h_aa[3:0], x0, y0);
            g10_reg <= gnz_pkg::grad(h_ba[3:0], x1m, y0);
            g01_reg <= gnz_pkg::grad(h_ab[3:0], x0, y1m);
            g11_reg <= gnz_pkg::grad(h_bb[3:0], x1m, y1m);
        end
        if (en[6])
        begin
            pu1_reg   <= gnz_pkg::prod_t'(u_fade) * gnz_pkg::prod_t'(g10_reg - g00_reg);
            pu2_reg   <= gnz_pkg::prod_t'(u_fade) * gnz_pkg::prod_t'(g11_reg - g01_reg);
            g00_6_reg <= g00_reg;
            g01_6_reg <= g01_reg;
            v6_reg    <= v_fade;
        end
        if (en[7])
        begin
            l1_reg <= g00_6_reg + gnz_pkg::rnd(pu1_reg);
            l2_reg <= g01_6_reg + gnz_pkg::rnd(pu2_reg);
            v7_reg <= v6_reg;
        end
        if (en[8])
        begin
            pv_reg   <= gnz_pkg::prod_t'(v7_reg) * gnz_pkg::prod_t'(l2_reg - l1_reg);
            l1_8_reg <= l1_reg;
        end
        if (en[9])
        begin
            noise_reg <= val_next[gnz_pkg::NOISE_W-1:0];
            above_reg <= val_next > 0;
        end
    end

    assign results.valid       = v_reg[9];
    assign results.noise_value = noise_reg;
    assign results.above_zero  = above_reg;

    a_load_interlock: assert property (@(posedge clk) disable iff (!rst_n)
        acc_load |-> !(v_reg[1] || v_reg[2] || v_reg[3]))
        else $error("table word taken while a sample is in the lookup stages");

    a_sample_enters: assert property (@(posedge clk) disable iff (!rst_n)
        acc_sample |=> v_reg[1])
        else $error("accepted sample word lost at the pipeline entry");

    a_result_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[8] && en[9]) |=> results.valid)
        else $error("sample dropped between the last stage and the output");

    a_sign_flag: assert property (@(posedge clk) disable iff (!rst_n)
        results.valid |-> (results.above_zero ==
            (!results.noise_value[gnz_pkg::NOISE_W-1] && results.noise_value != '0)))
        else $error("above_zero disagrees with the noise value");

endmodule
